[rtl/core/jvbs_pkg.sv]
// Shared types and constants for the JSON value boundary scanner.
// No dependencies; imported by every jvbs module and the top level.
package jvbs_pkg;

   localparam int DEPTH_WIDTH_DEF = 16;
   localparam int COUNT_WIDTH_DEF = 24;
   localparam int OUT_WIDTH       = 24;
   localparam logic [OUT_WIDTH-1:0] OUT_MAX = {OUT_WIDTH{1'b1}};

   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_COMMA     = 8'h2C;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FOUND = 2'd1,
      ST_OPEN  = 2'd2
   } status_type;

   typedef struct packed {
      logic       buffer_last;
      logic       scan_start;
      logic [7:0] in_byte;
   } req_item_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] newline_count;
      logic [OUT_WIDTH-1:0] value_length;
      status_type           scan_status;
   } rsp_item_type;

endpackage

[rtl/core/jvbs_in_stage.sv]
// Input register stage: captures one request transaction per cycle unless out_ready stalls it.
// Depends on jvbs_pkg.
module jvbs_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  jvbs_pkg::req_item_type in_item,
   input  logic                  out_ready,
   output logic                  advance,
   output jvbs_pkg::req_item_type stage_item
);
   import jvbs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign advance  = valid_ff && out_ready;
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_ready);
   assign stage_item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

[rtl/core/jvbs_scan_core.sv]
// Scan state and per-byte update: nesting depth, string/escape tracking,
// saturating byte and newline counters. Depends on jvbs_pkg.
module jvbs_scan_core #(
   parameter int DEPTH_WIDTH = jvbs_pkg::DEPTH_WIDTH_DEF,
   parameter int COUNT_WIDTH = jvbs_pkg::COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  jvbs_pkg::req_item_type item,
   output jvbs_pkg::rsp_item_type result
);
   import jvbs_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_NEST  = 2'd1,
      MODE_PLAIN = 2'd2
   } mode_type;

   localparam int EXT_WIDTH = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;

   mode_type               mode_ff, mode_in, eff_mode;
   logic [DEPTH_WIDTH-1:0] depth_ff, depth_in, eff_depth;
   logic                   str_ff, str_in, eff_str;
   logic                   esc_ff, esc_in, eff_esc;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in, eff_bytes;
   logic [COUNT_WIDTH-1:0] lines_ff, lines_in, eff_lines;
   logic [COUNT_WIDTH-1:0] bytes_inc, lines_inc;
   logic [EXT_WIDTH-1:0]   bytes_ext, lines_ext;
   logic [7:0]             b;
   logic                   done;
   status_type             status;

   assign b = item.in_byte;

   always_comb begin
      if (item.scan_start) begin
         eff_mode  = (b inside {CH_LBRACE, CH_LBRACKET, CH_QUOTE}) ? MODE_NEST : MODE_PLAIN;
         eff_depth = '0;
         eff_str   = 1'b0;
         eff_esc   = 1'b0;
         eff_bytes = '0;
         eff_lines = '0;
      end else begin
         eff_mode  = mode_ff;
         eff_depth = depth_ff;
         eff_str   = str_ff;
         eff_esc   = esc_ff;
         eff_bytes = bytes_ff;
         eff_lines = lines_ff;
      end

      bytes_inc = (&eff_bytes) ? eff_bytes : eff_bytes + 1'b1;
      lines_inc = (&eff_lines) ? eff_lines : eff_lines + 1'b1;

      mode_in  = eff_mode;
      depth_in = eff_depth;
      str_in   = eff_str;
      esc_in   = eff_esc;
      bytes_in = eff_bytes;
      lines_in = eff_lines;
      done     = 1'b0;
      status   = ST_IDLE;

      case (eff_mode)
         MODE_NEST: begin
            bytes_in = bytes_inc;
            if (eff_str) begin
               if (eff_esc) begin
                  esc_in = 1'b0;
               end else if (b == CH_QUOTE) begin
                  str_in = 1'b0;
                  done   = (eff_depth == '0);
               end else if (b == CH_BACKSLASH) begin
                  esc_in = 1'b1;
               end else if (b == CH_NEWLINE) begin
                  lines_in = lines_inc;
               end
            end else begin
               if (b inside {CH_LBRACE, CH_LBRACKET}) begin
                  depth_in = (&eff_depth) ? eff_depth : eff_depth + 1'b1;
               end else if (b inside {CH_RBRACE, CH_RBRACKET}) begin
                  depth_in = (eff_depth != '0) ? eff_depth - 1'b1 : eff_depth;
                  done     = (depth_in == '0);
               end else if (b == CH_QUOTE) begin
                  str_in = 1'b1;
               end else if (b == CH_NEWLINE) begin
                  lines_in = lines_inc;
               end
            end
            if (item.buffer_last) begin
               status = ST_OPEN;
            end else if (done) begin
               status = ST_FOUND;
            end
         end
         MODE_PLAIN: begin
            if (b inside {CH_COMMA, CH_RBRACKET}) begin
               status = ST_FOUND;
            end else begin
               bytes_in = bytes_inc;
               if (b == CH_NEWLINE) begin
                  lines_in = lines_inc;
               end
               if (item.buffer_last) begin
                  status = ST_OPEN;
               end
            end
         end
         default: begin
         end
      endcase

      if (status != ST_IDLE) begin
         mode_in  = MODE_IDLE;
         depth_in = '0;
         str_in   = 1'b0;
         esc_in   = 1'b0;
      end

      bytes_ext = EXT_WIDTH'(bytes_in);
      lines_ext = EXT_WIDTH'(lines_in);

      if (eff_mode == MODE_IDLE) begin
         result.scan_status   = ST_IDLE;
         result.value_length  = '0;
         result.newline_count = '0;
      end else begin
         result.scan_status   = status;
         result.value_length  = (bytes_ext > EXT_WIDTH'(OUT_MAX)) ? OUT_MAX
                                                                  : bytes_ext[OUT_WIDTH-1:0];
         result.newline_count = (lines_ext > EXT_WIDTH'(OUT_MAX)) ? OUT_MAX
                                                                  : lines_ext[OUT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         depth_ff <= '0;
         str_ff   <= 1'b0;
         esc_ff   <= 1'b0;
         bytes_ff <= '0;
         lines_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
         str_ff   <= str_in;
         esc_ff   <= esc_in;
         bytes_ff <= bytes_in;
         lines_ff <= lines_in;
      end
   end

endmodule

[rtl/core/jvbs_out_stage.sv]
// Result register stage: holds one response transaction until taken.
// Depends on jvbs_pkg.
module jvbs_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  jvbs_pkg::rsp_item_type load_item,
   output logic                   load_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output jvbs_pkg::rsp_item_type out_item
);
   import jvbs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign load_ready = !valid_ff || out_ready;
   assign valid_in   = load || (valid_ff && !out_ready);
   assign out_valid  = valid_ff;
   assign out_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

[rtl/core/json_value_boundary_scanner_top.sv]
// A request passes the input register, single-pass scan update and result
// register. Throughput: one byte per cycle unless rsp_tready stalls, the
// scan state updated once per byte.
// Reset (synchronous, active high) empties both register stages and returns
// the scanner to idle with depth, string state and counters cleared.
module json_value_boundary_scanner_top #(
   parameter int DEPTH_WIDTH = jvbs_pkg::DEPTH_WIDTH_DEF,
   parameter int COUNT_WIDTH = jvbs_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] scan_start
   input  logic        req_tlast,   // buffer_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] value_length, [47:24] newline_count
   output logic [1:0]  rsp_tuser    // [1:0] scan_status
);
   import jvbs_pkg::*;

   req_item_type req_item, stage_item;
   rsp_item_type scan_result, rsp_item;
   logic         advance;
   logic         load_ready;

   assign req_item.in_byte     = req_tdata;
   assign req_item.scan_start  = req_tuser;
   assign req_item.buffer_last = req_tlast;

   jvbs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .out_ready  (load_ready),
      .advance    (advance),
      .stage_item (stage_item)
   );

   jvbs_scan_core #(
      .DEPTH_WIDTH (DEPTH_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scan_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_item),
      .result  (scan_result)
   );

   jvbs_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_item  (scan_result),
      .load_ready (load_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (rsp_item)
   );

   assign rsp_tdata = {rsp_item.newline_count, rsp_item.value_length};
   assign rsp_tuser = rsp_item.scan_status;

endmodule
